@@ rtl/sle_pkg.sv @@
`default_nettype none

package sle_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_DUMP_ASC  = 3'd1,
    ACT_DUMP_DESC = 3'd2,
    ACT_REMOVE    = 3'd3,
    ACT_CLEAR     = 3'd4
  } sle_action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } sle_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_INS_RD,
    S_INS_EV,
    S_REM_RD,
    S_REM_EV,
    S_DMP_RD,
    S_DMP_EV
  } sle_state_e;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned RemovedW = 5;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [ValueW-1:0] value;
  } sle_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] item_value;
    logic [RemovedW-1:0]      removed_count;
    logic                     last;
  } sle_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        capture;
    logic        set_resp;
    sle_status_e resp_status;
    logic        emit_single;
    logic        emit_dump;
    logic        ins_start;
    logic        ins_rd;
    logic        ins_write_value;
    logic        ins_shift;
    logic        count_inc;
    logic        rem_start;
    logic        rem_rd;
    logic        rem_ev;
    logic        rem_finish;
    logic        dmp_start;
    logic        dmp_rd;
    logic        dmp_next;
    logic        clear;
  } sle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic full;
    logic ptr_zero;
    logic less;
    logic scan_done;
    logic dump_last;
    logic out_free;
  } sle_stat_t;

endpackage

`default_nettype wire

@@ rtl/sle_stream_if.sv @@
`default_nettype none

interface sle_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/sle_ram.sv @@
`default_nettype none

module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sle_ctrl.sv @@
`default_nettype none

module sle_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [2:0]        in_action_i,
  input  wire sle_pkg::sle_stat_t stat_i,
  output sle_pkg::sle_cmd_t      cmd_o,
  output logic                   in_ready_o
);
  import sle_pkg::*;

  sle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_action_i)
            ACT_INSERT: begin
              if (stat_i.full) begin
                cmd_o.set_resp    = 1'b1;
                cmd_o.resp_status = ST_FULL;
                state_d           = S_RESP;
              end else begin
                cmd_o.ins_start = 1'b1;
                state_d         = S_INS_RD;
              end
            end
            ACT_DUMP_ASC, ACT_DUMP_DESC: begin
              if (stat_i.count_zero) begin
                cmd_o.set_resp    = 1'b1;
                cmd_o.resp_status = ST_EMPTY;
                state_d           = S_RESP;
              end else begin
                cmd_o.dmp_start = 1'b1;
                state_d         = S_DMP_RD;
              end
            end
            ACT_REMOVE: begin
              if (stat_i.count_zero) begin
                cmd_o.set_resp    = 1'b1;
                cmd_o.resp_status = ST_EMPTY;
                state_d           = S_RESP;
              end else begin
                cmd_o.rem_start = 1'b1;
                state_d         = S_REM_RD;
              end
            end
            ACT_CLEAR: begin
              cmd_o.set_resp = 1'b1;
              if (stat_i.count_zero) begin
                cmd_o.resp_status = ST_EMPTY;
              end else begin
                cmd_o.resp_status = ST_OK;
                cmd_o.clear       = 1'b1;
              end
              state_d = S_RESP;
            end
            default: begin
              // Undefined actions are dropped without a result.
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_INS_RD: begin
        if (stat_i.ptr_zero) begin
          cmd_o.ins_write_value = 1'b1;
          cmd_o.count_inc       = 1'b1;
          cmd_o.set_resp        = 1'b1;
          cmd_o.resp_status     = ST_OK;
          state_d               = S_RESP;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = S_INS_EV;
        end
      end
      S_INS_EV: begin
        if (stat_i.less) begin
          cmd_o.ins_write_value = 1'b1;
          cmd_o.count_inc       = 1'b1;
          cmd_o.set_resp        = 1'b1;
          cmd_o.resp_status     = ST_OK;
          state_d               = S_RESP;
        end else begin
          cmd_o.ins_shift = 1'b1;
          state_d         = S_INS_RD;
        end
      end
      S_REM_RD: begin
        if (stat_i.scan_done) begin
          cmd_o.rem_finish = 1'b1;
          state_d          = S_RESP;
        end else begin
          cmd_o.rem_rd = 1'b1;
          state_d      = S_REM_EV;
        end
      end
      S_REM_EV: begin
        cmd_o.rem_ev = 1'b1;
        state_d      = S_REM_RD;
      end
      S_DMP_RD: begin
        cmd_o.dmp_rd = 1'b1;
        state_d      = S_DMP_EV;
      end
      S_DMP_EV: begin
        if (stat_i.out_free) begin
          cmd_o.emit_dump = 1'b1;
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.dmp_next = 1'b1;
            state_d        = S_DMP_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sle_datapath.sv @@
`default_nettype none

module sle_datapath #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sle_pkg::sle_in_t  in_payload_i,
  input  wire sle_pkg::sle_cmd_t cmd_i,
  output sle_pkg::sle_stat_t     stat_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output sle_pkg::sle_out_t      out_payload_o
);
  import sle_pkg::*;

  localparam int unsigned GW = (CW > RemovedW) ? CW : RemovedW;

  logic [CW-1:0]            count_q;
  logic [CW-1:0]            r_q;
  logic [CW-1:0]            k_q;
  logic [AW-1:0]            ptr_q;
  logic [AW-1:0]            j_q;
  logic signed [ValueW-1:0] value_q;
  logic                     desc_q;
  sle_status_e              resp_status_q;
  logic [RemovedW-1:0]      resp_removed_q;
  sle_out_t                 out_q;
  logic                     out_valid_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic              out_free;
  logic              full;
  logic              eq;
  logic [CW-1:0]     desc_addr;
  logic [GW-1:0]     gone;
  logic [RemovedW-1:0] gone_sat;

  sle_ram #(
    .WIDTH (ValueW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign full      = (count_q == CW'(CAPACITY));
  assign eq        = (ram_rdata == value_q);
  assign desc_addr = count_q - CW'(1) - CW'(j_q);
  assign gone      = GW'(count_q) - GW'(k_q);
  assign gone_sat  = (gone > GW'(31)) ? RemovedW'(31) : gone[RemovedW-1:0];

  always_comb begin
    stat_o.count_zero = (count_q == '0);
    stat_o.full       = full;
    stat_o.ptr_zero   = (ptr_q == '0);
    stat_o.less       = ($signed(ram_rdata) < value_q);
    stat_o.scan_done  = (r_q == count_q);
    stat_o.dump_last  = ((CW'(j_q) + CW'(1)) == count_q);
    stat_o.out_free   = out_free;
  end

  // Insert walks down from the top, moving each entry not smaller than the new
  // value up by one until its slot is found. Remove compacts the kept entries.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = value_q;
    ram_re    = 1'b0;
    ram_raddr = ptr_q - AW'(1);
    if (cmd_i.ins_write_value) begin
      ram_we = 1'b1;
    end
    if (cmd_i.ins_shift) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end
    if (cmd_i.rem_ev && !eq) begin
      ram_we    = 1'b1;
      ram_waddr = k_q[AW-1:0];
      ram_wdata = ram_rdata;
    end
    if (cmd_i.ins_rd) begin
      ram_re = 1'b1;
    end
    if (cmd_i.rem_rd) begin
      ram_re    = 1'b1;
      ram_raddr = r_q[AW-1:0];
    end
    if (cmd_i.dmp_rd) begin
      ram_re    = 1'b1;
      ram_raddr = desc_q ? desc_addr[AW-1:0] : j_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      r_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.rem_finish) begin
        count_q <= k_q;
      end
      if (cmd_i.rem_start) begin
        r_q <= '0;
        k_q <= '0;
      end else if (cmd_i.rem_ev) begin
        r_q <= r_q + CW'(1);
        if (!eq) begin
          k_q <= k_q + CW'(1);
        end
      end
      if (cmd_i.emit_single || cmd_i.emit_dump) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= in_payload_i.value;
      desc_q  <= (in_payload_i.action == ACT_DUMP_DESC);
    end
    if (cmd_i.set_resp) begin
      resp_status_q  <= cmd_i.resp_status;
      resp_removed_q <= '0;
    end else if (cmd_i.rem_finish) begin
      resp_status_q  <= (gone == '0) ? ST_NOTFOUND : ST_OK;
      resp_removed_q <= gone_sat;
    end
    if (cmd_i.ins_start) begin
      ptr_q <= count_q[AW-1:0];
    end else if (cmd_i.ins_shift) begin
      ptr_q <= ptr_q - AW'(1);
    end
    if (cmd_i.dmp_start) begin
      j_q <= '0;
    end else if (cmd_i.dmp_next) begin
      j_q <= j_q + AW'(1);
    end
    if (cmd_i.emit_single) begin
      out_q.status        <= resp_status_q;
      out_q.item_value    <= value_q;
      out_q.removed_count <= resp_removed_q;
      out_q.last          <= 1'b1;
    end else if (cmd_i.emit_dump) begin
      out_q.status        <= ST_OK;
      out_q.item_value    <= ram_rdata;
      out_q.removed_count <= '0;
      out_q.last          <= stat_o.dump_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_single || cmd_i.emit_dump) |-> out_free)
    else $error("result loaded while output register still occupied");

  a_keep_le_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= r_q)
    else $error("compaction write index passed the scan index");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_inc |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the list by one");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_inc |-> !full)
    else $error("insert committed into a full list");

endmodule

`default_nettype wire

@@ rtl/sorted_list_engine_unit.sv @@
// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending
// order in a single memory with one write and one registered read port. Each
// input item carries an action (insert, dump ascending, dump descending,
// remove all equal, clear) and a value; the block takes one item at a time and
// raises ready only while it is idle. The memory's read is registered. An
// insert walks down from the top of the list and moves up by one each entry
// not smaller than the new value; a remove scans every entry of the list; a
// dump reads each entry from the memory before it gives it as a result;
// clear, an insert into a full list and a dump, remove or clear on an empty
// list give only a status result. Results leave through an output register,
// so the engine keeps working while a result waits, but any step that loads
// a result stalls until the previous one has been taken. Actions 5 to 7 are
// dropped without a result. There is no clearing pass after reset.
`default_nettype none

module sorted_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sle_stream_if.sink   in_i,
  sle_stream_if.source out_o
);
  import sle_pkg::*;

  sle_cmd_t  cmd;
  sle_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  sle_out_t  out_payload;
  sle_in_t   in_payload;

  assign in_payload = in_i.payload;

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_payload.action),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready)
  );

  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_payload_i  (in_payload),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .out_payload_o (out_payload)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_payload;

endmodule

`default_nettype wire
